// ----- design/pcm16_rms_level_meter_macros.svh -----
// Assertion macros used by the checker file.
// The macros expect a signal named clk, and PRLM_ASSERT also rst_n, in the scope where they are used.
`ifndef PCM16_RMS_LEVEL_METER_MACROS_SVH
`define PCM16_RMS_LEVEL_METER_MACROS_SVH

// Checked only while the block is out of reset.
`define PRLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, including those in reset.
`define PRLM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/prlm_pkg.sv -----
`default_nettype none
package prlm_pkg;

  localparam int unsigned SQ_W            = 31;
  localparam int unsigned LEVEL_W         = 17;
  localparam int unsigned ROOT_STEPS      = 16;
  localparam int unsigned ROOT_CLAMP      = 4096;
  localparam int unsigned MAX_SAMPLES_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'h10000;

  typedef struct packed {
    logic [SQ_W-1:0] sq;
    logic            last;
  } prlm_item_t;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DIV,
    ST_ROOT,
    ST_OUT
  } prlm_state_t;

endpackage
`default_nettype wire

// ----- design/prlm_fifo.sv -----
`default_nettype none
module prlm_fifo #(
  parameter int unsigned DEPTH = prlm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  prlm_pkg::prlm_item_t      push_item,
  output logic                      full,
  input  wire logic                 pop,
  output prlm_pkg::prlm_item_t      pop_item,
  output logic                      empty
);
  import prlm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  prlm_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- design/prlm_front.sv -----
`default_nettype none
module prlm_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [15:0]    in_sample,
  input  wire logic                  in_last,
  input  wire logic                  q_full,
  output logic                       q_push,
  output prlm_pkg::prlm_item_t       q_item
);
  import prlm_pkg::*;

  logic              ent_v_r, ent_v_nxt;
  prlm_item_t        ent_r;
  logic signed [31:0] prod;
  logic              accept;

  assign prod     = in_sample * in_sample;
  assign q_push   = ent_v_r && !q_full;
  assign in_ready = !ent_v_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_item   = ent_r;

  always_comb begin
    ent_v_nxt = ent_v_r;
    if (accept) begin
      ent_v_nxt = 1'b1;
    end else if (q_push) begin
      ent_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_v_r <= 1'b0;
    end else begin
      ent_v_r <= ent_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent_r.sq   <= prod[SQ_W-1:0];
      ent_r.last <= in_last;
    end
  end

endmodule
`default_nettype wire

// ----- design/prlm_back.sv -----
`default_nettype none
module prlm_back #(
  parameter int unsigned MAX_SAMPLES = prlm_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_empty,
  output logic                               q_pop,
  input  prlm_pkg::prlm_item_t               q_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [prlm_pkg::LEVEL_W-1:0]       out_level,
  output logic                               out_overflow
);
  import prlm_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W  = SQ_W + CNT_W;
  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  prlm_state_t        state_r, state_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [SQ_W-1:0]    sqv_r, sqv_nxt;
  logic [SQ_W:0]      root_r, root_nxt;
  logic [SQ_W-1:0]    bit_r, bit_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic               room;
  logic [CNT_W:0]     div_shift, div_diff;
  logic               div_ok;
  logic [SQ_W:0]      root_try;
  logic               sq_ok;
  logic [LEVEL_W-1:0] level_calc;

  assign room       = (cnt_r < CNT_W'(MAX_SAMPLES));
  assign div_shift  = {rem_r, sum_r[SUM_W-1]};
  assign div_diff   = div_shift - {1'b0, cnt_r};
  assign div_ok     = !div_diff[CNT_W];
  assign root_try   = root_r + {1'b0, bit_r};
  assign sq_ok      = ({1'b0, sqv_r} >= root_try);
  assign level_calc = (root_r >= (SQ_W+1)'(ROOT_CLAMP)) ? LEVEL_ONE
                                                        : {1'b0, root_r[11:0], 4'b0000};

  assign q_pop        = (state_r == ST_ACC) && !q_empty;
  assign out_valid    = out_valid_r;
  assign out_level    = level_r;
  assign out_overflow = out_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    sqv_nxt       = sqv_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    level_nxt     = level_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      ST_ACC: begin
        if (q_pop) begin
          if (room) begin
            sum_nxt = sum_r + SUM_W'(q_item.sq);
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (q_item.last) begin
            state_nxt = ST_DIV;
            step_nxt  = '0;
            rem_nxt   = '0;
          end
        end
      end
      ST_DIV: begin
        sum_nxt  = {sum_r[SUM_W-2:0], div_ok};
        rem_nxt  = div_ok ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          state_nxt = ST_ROOT;
          step_nxt  = '0;
          sqv_nxt   = sum_nxt[SQ_W-1:0];
          root_nxt  = '0;
          bit_nxt   = {1'b1, {(SQ_W-1){1'b0}}};
        end
      end
      ST_ROOT: begin
        if (sq_ok) begin
          sqv_nxt  = SQ_W'({1'b0, sqv_r} - root_try);
          root_nxt = (root_r >> 1) + {1'b0, bit_r};
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt  = bit_r >> 2;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(ROOT_STEPS - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          level_nxt     = level_calc;
          out_ovf_nxt   = ovf_r;
          sum_nxt       = '0;
          cnt_nxt       = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      sum_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    step_r    <= step_nxt;
    sqv_r     <= sqv_nxt;
    root_r    <= root_nxt;
    bit_r     <= bit_nxt;
    level_r   <= level_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

endmodule
`default_nettype wire

// ----- design/pcm16_rms_level_meter.sv -----
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_sample (s16), in_last (1)
// out      output     out_valid/out_ready  out_level (u17, Q1.16), out_overflow (1)
//
// A sample that does not end a chunk is added to the running sum and count in the accumulator.
// A chunk's last sample also starts the bit-serial divider and then the bit-serial square root,
// after which ST_OUT loads the result into the output register.
// A four-entry request queue lets the front keep accepting samples while they run.
// Synchronous active-low reset clears the control state; there is no clearing pass.
// A stalled result waits in the output register while the next chunk accumulates.
`default_nettype none
module pcm16_rms_level_meter #(
  parameter int unsigned MAX_SAMPLES = prlm_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned QUEUE_DEPTH = prlm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [15:0]        in_sample,
  input  wire logic                      in_last,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [prlm_pkg::LEVEL_W-1:0]   out_level,
  output logic                           out_overflow
);
  import prlm_pkg::*;

  prlm_item_t push_item, pop_item;
  logic       q_push, q_full, q_pop, q_empty;

  prlm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .in_last   (in_last),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  prlm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  prlm_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_item       (pop_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_level    (out_level),
    .out_overflow (out_overflow)
  );

endmodule
`default_nettype wire

// ----- design/prlm_checker.sv -----
`default_nettype none
`include "pcm16_rms_level_meter_macros.svh"
module prlm_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [prlm_pkg::LEVEL_W-1:0] out_level,
  input wire logic                         out_overflow
);
  import prlm_pkg::*;

  property p_out_hold;
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_overflow);
  endproperty

  `PRLM_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")
  `PRLM_ASSERT(a_level_range, out_valid |-> (out_level <= LEVEL_ONE), "level above full scale")
  `PRLM_ASSERT(a_out_hold, p_out_hold, "stalled result changed")
  `PRLM_ASSERT(a_level_grain, out_valid |-> (out_level[3:0] == 4'b0000), "level not a multiple of sixteen")

endmodule

bind pcm16_rms_level_meter prlm_checker u_prlm_checker (.*);
`default_nettype wire

// ----- test/pcm16_rms_level_meter_test.sv -----
`default_nettype none
module pcm16_rms_level_meter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import prlm_pkg::*;

  localparam int unsigned CHUNK_LIMIT = MAX_SAMPLES_DEF;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS_PER_PHASE = 275;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               overflow;
  } chunk_level_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [15:0]        in_sample = '0;
  logic                      in_last = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [LEVEL_W-1:0]        out_level;
  logic                      out_overflow;

  // Running chunk state mirrored from the meter.
  logic [63:0]               chunk_square_sum = '0;
  int unsigned               chunk_sample_count = 0;
  logic                      chunk_overflowed = 1'b0;
  chunk_level_t              pending_levels[$];

  int unsigned               send_idle_pct = 0;
  int unsigned               recv_stall_pct = 0;
  int unsigned               error_count = 0;
  longint unsigned           cycle_count = 0;

  pcm16_rms_level_meter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_level   (out_level),
    .out_overflow(out_overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      if (64'(trial) * 64'(trial) <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  task automatic accumulate_sample(input logic signed [15:0] s, input logic l);
    longint       mag;
    logic [63:0]  mean;
    logic [63:0]  lvl;
    chunk_level_t want;
    mag = (s < 0) ? -longint'(s) : longint'(s);
    if (chunk_sample_count < CHUNK_LIMIT) begin
      chunk_square_sum += 64'(mag * mag);
      chunk_sample_count++;
    end else begin
      chunk_overflowed = 1'b1;
    end
    if (l) begin
      mean = chunk_square_sum / 64'(chunk_sample_count);
      lvl = 64'(floor_sqrt(mean)) * 64'd16;
      if (lvl > 64'(LEVEL_ONE)) begin
        lvl = 64'(LEVEL_ONE);
      end
      want.level = lvl[LEVEL_W-1:0];
      want.overflow = chunk_overflowed;
      pending_levels.push_back(want);
      chunk_square_sum = '0;
      chunk_sample_count = 0;
      chunk_overflowed = 1'b0;
    end
  endtask

  always @(posedge clk) begin : check_levels
    chunk_level_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected result level=%0d overflow=%0b",
                                  out_level, out_overflow));
      end else begin
        want = pending_levels.pop_front();
        if (out_level !== want.level) begin
          report_mismatch($sformatf("level %0d, expected %0d", out_level, want.level));
        end
        if (out_overflow !== want.overflow) begin
          report_mismatch($sformatf("overflow %0b, expected %0b",
                                    out_overflow, want.overflow));
        end
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with the request still held.
  task automatic send_sample(input logic signed [15:0] s, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_last <= l;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    accumulate_sample(s, l);
    @(negedge clk);
  endtask

  task automatic wait_for_levels;
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic logic signed [15:0] random_sample(input int unsigned bound);
    int v;
    if ($urandom_range(15) == 0) begin
      return 16'sh8000;
    end
    if (bound >= 32767 && $urandom_range(1) == 0) begin
      return 16'($urandom());
    end
    v = int'($urandom_range(0, 2 * bound)) - int'(bound);
    return 16'(v);
  endfunction

  task automatic test_single_sample_levels;
    logic signed [15:0] cases[12];
    cases = '{16'sd0, 16'sd1, -16'sd1, 16'sd15, 16'sd64, 16'sd4095, 16'sd4096,
              16'sd4097, -16'sd4097, 16'sd32767, -16'sd32767, 16'sh8000};
    foreach (cases[i]) begin
      send_sample(cases[i], 1'b1);
    end
  endtask

  task automatic test_short_chunks;
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd4, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(-16'sd2000, 1'b0);
    send_sample(16'sd2000, 1'b0);
    send_sample(16'sd0, 1'b1);
  endtask

  task automatic test_random_chunks(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    int unsigned bound;
    int unsigned bounds[5];
    bounds = '{15, 255, 4095, 8191, 32767};
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < RANDOM_ITEMS_PER_PHASE) begin
      r = $urandom_range(99);
      if (r < 70) begin
        len = $urandom_range(1, 8);
      end else if (r < 95) begin
        len = $urandom_range(9, 64);
      end else begin
        len = $urandom_range(65, 400);
      end
      bound = bounds[$urandom_range(4)];
      for (int unsigned i = 1; i <= len; i++) begin
        send_sample(random_sample(bound), i == len);
      end
      sent += len;
      if ($urandom_range(7) == 0) begin
        wait_for_levels();
      end
    end
    wait_for_levels();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_single_sample_levels();
    test_short_chunks();
    wait_for_levels();
    test_random_chunks(0, 0);
    test_random_chunks(69, 0);
    test_random_chunks(0, 69);
    test_random_chunks(15, 15);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/prlm_pkg.sv
design/prlm_fifo.sv
design/prlm_front.sv
design/prlm_back.sv
design/pcm16_rms_level_meter.sv
design/prlm_checker.sv
test/pcm16_rms_level_meter_test.sv
